/* sv/cpf_pkg.sv */
// Shared constants and types for the closest adjacent pairs finder.
`default_nettype none
package cpf_pkg;

  localparam int CAPACITY    = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int VAL_W       = 32;

  typedef logic [VAL_W-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } item_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage
`default_nettype wire

/* sv/cpf_front.sv */
// Intake side: accepts items and holds them in a short queue for the sorter.
`default_nettype none
module cpf_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  cpf_pkg::item_t   in_item,
  output logic             q_valid,
  output cpf_pkg::item_t   q_item,
  input  wire              q_pop
);
  import cpf_pkg::*;

  item_t             q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;
  logic              push;
  logic              pop;

  assign in_ready = (fill_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

/* sv/cpf_back.sv */
// Work side: insertion-sort row, minimum gap scan and pair emission.
`default_nettype none
module cpf_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_valid,
  input  cpf_pkg::item_t         q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [cpf_pkg::VAL_W-1:0] out_lower_value,
  output logic [cpf_pkg::VAL_W-1:0] out_upper_value,
  output logic [cpf_pkg::VAL_W-1:0] out_pair_gap,
  output logic                   out_pair_present,
  output logic                   out_capacity_overflow,
  output logic                   out_final_result
);
  import cpf_pkg::*;

  state_t           state_r, state_nxt;
  value_t           row_r [CAPACITY];
  value_t           ins_row [CAPACITY];
  logic [CAPACITY-1:0] shift_c;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  value_t           min_r, min_nxt;
  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic             single_r, single_nxt;
  logic             out_valid_r;
  value_t           lower_r, upper_r, gap_r;
  logic             present_r, ovf_out_r, final_r;

  logic   take, store_ok, step_ok, slot_free, hit;
  logic   row_ins, row_rot, out_load, load_present, load_final;
  value_t gap_c;

  assign q_pop     = (state_r == ST_LOAD);
  assign take      = q_pop && q_valid;
  assign store_ok  = (cnt_r != CNT_W'(CAPACITY));
  assign gap_c     = row_r[1] - row_r[0];
  assign step_ok   = ((CNT_W'(step_r) + CNT_W'(1)) < cnt_r);
  assign hit       = step_ok && (gap_c == min_r);
  assign slot_free = !out_valid_r || out_ready;

  // Each cell shifts when the new value belongs at or before it.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    assign shift_c[k] = (CNT_W'(k) < cnt_r) ?
                        ($signed(q_item.value) < $signed(row_r[k])) :
                        (CNT_W'(k) == cnt_r);
    if (k == 0) begin : g_head
      assign ins_row[k] = shift_c[k] ? q_item.value : row_r[k];
    end else begin : g_body
      assign ins_row[k] = shift_c[k] ? (shift_c[k-1] ? row_r[k-1] : q_item.value)
                                     : row_r[k];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    step_nxt     = step_r;
    min_nxt      = min_r;
    last_idx_nxt = last_idx_r;
    single_nxt   = single_r;
    row_ins      = 1'b0;
    row_rot      = 1'b0;
    out_load     = 1'b0;
    load_present = 1'b0;
    load_final   = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (take) begin
          if (store_ok) begin
            row_ins = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_item.last) begin
            step_nxt = '0;
            if (store_ok && cnt_r == '0) begin
              single_nxt = 1'b1;
              state_nxt  = ST_EMIT;
            end else begin
              single_nxt = 1'b0;
              state_nxt  = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // one full rotation of the row; gaps past the fill are ignored
        row_rot  = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_ok) begin
          if (step_r == '0 || gap_c < min_r) begin
            min_nxt      = gap_c;
            last_idx_nxt = step_r;
          end else if (gap_c == min_r) begin
            last_idx_nxt = step_r;
          end
        end
        if (step_r == IDX_W'(CAPACITY - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (single_r) begin
            out_load     = 1'b1;
            load_present = 1'b0;
            load_final   = 1'b1;
          end else begin
            row_rot  = 1'b1;
            step_nxt = step_r + 1'b1;
            if (hit) begin
              out_load     = 1'b1;
              load_present = 1'b1;
              load_final   = (step_r == last_idx_r);
            end
          end
          if (out_load && load_final) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    min_r      <= min_nxt;
    last_idx_r <= last_idx_nxt;
    single_r   <= single_nxt;
    for (int k = 0; k < CAPACITY; k++) begin
      if (row_ins) begin
        row_r[k] <= ins_row[k];
      end else if (row_rot) begin
        row_r[k] <= row_r[(k + 1) % CAPACITY];
      end
    end
    if (out_load) begin
      lower_r   <= row_r[0];
      upper_r   <= single_r ? row_r[0] : row_r[1];
      gap_r     <= single_r ? '0 : gap_c;
      present_r <= load_present;
      ovf_out_r <= ovf_r;
      final_r   <= load_final;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_lower_value       = lower_r;
  assign out_upper_value       = upper_r;
  assign out_pair_gap          = gap_r;
  assign out_pair_present      = present_r;
  assign out_capacity_overflow = ovf_out_r;
  assign out_final_result      = final_r;

endmodule
`default_nettype wire

/* sv/closest_adjacent_pairs_finder_core.sv */
// Top level of the closest adjacent pairs finder.
// Collects up to 16 signed Q16.16 values per set, one transfer per cycle while
// in_ready is high, into a sorted insertion row; the value flagged end_of_set
// closes the set, and values past the 16th are dropped with capacity_overflow set
// on every result of that set. After the closing value the row is rotated once to
// find the minimum neighbor gap, then stepped again to emit every neighboring pair
// at that gap in ascending order, stopping at the pair marked final_result; the
// stepping waits while the output is stalled. A one-value set gives a single
// result with pair_present low.
// A four-entry queue ahead of the sorter keeps taking values while the scan runs;
// the output register lets the next result wait while the consumer stalls.
`default_nettype none
module closest_adjacent_pairs_finder_core (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire signed [31:0]         in_sample_value,
  input  wire                       in_end_of_set,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic signed [31:0]        out_lower_value,
  output logic signed [31:0]        out_upper_value,
  output logic [31:0]               out_pair_gap,
  output logic                      out_pair_present,
  output logic                      out_capacity_overflow,
  output logic                      out_final_result
);
  import cpf_pkg::*;

  item_t  in_item;
  item_t  q_item;
  logic   q_valid;
  logic   q_pop;
  value_t lower_w, upper_w;

  assign in_item.value = value_t'(in_sample_value);
  assign in_item.last  = in_end_of_set;

  cpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  cpf_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_lower_value       (lower_w),
    .out_upper_value       (upper_w),
    .out_pair_gap          (out_pair_gap),
    .out_pair_present      (out_pair_present),
    .out_capacity_overflow (out_capacity_overflow),
    .out_final_result      (out_final_result)
  );

  assign out_lower_value = $signed(lower_w);
  assign out_upper_value = $signed(upper_w);

endmodule
`default_nettype wire

/* sv/cpf_checker.sv */
// Port-level checks for the closest adjacent pairs finder, bound to the top level.
`default_nettype none
module cpf_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [31:0] out_lower_value,
  input wire signed [31:0] out_upper_value,
  input wire        [31:0] out_pair_gap,
  input wire               out_pair_present,
  input wire               out_final_result
);

  // a pending result stays until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // a result without a pair is always the only and last one
  a_single_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pair_present |-> out_final_result)
    else $error("pairless result not marked final");

  a_gap_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pair_gap == 32'(out_upper_value - out_lower_value)))
    else $error("gap does not match pair");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pair_present |-> (out_lower_value <= out_upper_value))
    else $error("pair out of order");

endmodule

bind closest_adjacent_pairs_finder_core cpf_checker u_cpf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_lower_value  (out_lower_value),
  .out_upper_value  (out_upper_value),
  .out_pair_gap     (out_pair_gap),
  .out_pair_present (out_pair_present),
  .out_final_result (out_final_result)
);
`default_nettype wire

/* verif/closest_adjacent_pairs_finder_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for closest_adjacent_pairs_finder_core.
module closest_adjacent_pairs_finder_core_test;
  import cpf_pkg::*;

  localparam int LONG_HOLD    = 400;
  localparam int LIMIT        = 300000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 150;
  localparam int QUIET_ITEMS  = 60;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;

  typedef enum int {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_LATTICE,
    SPREAD_CLUSTER,
    SPREAD_EXTREMES
  } spread_t;

  typedef struct packed {
    logic [31:0] lower;
    logic [31:0] upper;
    logic [31:0] gap;
    logic        present;
    logic        overflow;
    logic        final_flag;
  } pair_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  wire                in_ready;
  logic signed [31:0] in_sample_value = '0;
  logic               in_end_of_set = 1'b0;
  wire                out_valid;
  logic               out_ready = 1'b0;
  wire signed [31:0]  out_lower_value;
  wire signed [31:0]  out_upper_value;
  wire [31:0]         out_pair_gap;
  wire                out_pair_present;
  wire                out_capacity_overflow;
  wire                out_final_result;

  // predictor state: values of the open set and expected closest pairs
  logic [31:0] set_values[$];
  logic        set_overflow = 1'b0;
  pair_t       pending_pairs[$];
  int          error_count = 0;

  bit          idle_en = 1'b1;
  int          burst_left = 0;
  bit          stall_en = 1'b1;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic [7:0]  stall_pattern = 8'ha5;
  logic [5:0]  pattern_age = '0;
  int          cycle_count = 0;

  closest_adjacent_pairs_finder_core uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_sample_value       (in_sample_value),
    .in_end_of_set         (in_end_of_set),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_lower_value       (out_lower_value),
    .out_upper_value       (out_upper_value),
    .out_pair_gap          (out_pair_gap),
    .out_pair_present      (out_pair_present),
    .out_capacity_overflow (out_capacity_overflow),
    .out_final_result      (out_final_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("closest_adjacent_pairs_finder_core test failed");
      $finish;
    end
  end

  // Stores one value unless the set is full; on the closing value sorts the set and
  // queues every neighbor pair at the minimum gap, or one pairless result for a one-value set.
  function automatic void predict_pairs(logic [31:0] value, logic last);
    logic [31:0] sorted_vals [CAPACITY];
    logic [31:0] x;
    logic [31:0] min_gap;
    int          n;
    int          j;
    int          last_idx;
    pair_t       r;
    if (set_values.size() < CAPACITY) set_values.push_back(value);
    else set_overflow = 1'b1;
    if (!last) return;
    n = set_values.size();
    if (n == 1) begin
      r = '{set_values[0], set_values[0], 32'd0, 1'b0, set_overflow, 1'b1};
      pending_pairs.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        x = set_values[i];
        j = i;
        while (j > 0 && $signed(x) < $signed(sorted_vals[j-1])) begin
          sorted_vals[j] = sorted_vals[j-1];
          j--;
        end
        sorted_vals[j] = x;
      end
      min_gap = sorted_vals[1] - sorted_vals[0];
      for (int i = 2; i < n; i++)
        if (sorted_vals[i] - sorted_vals[i-1] < min_gap) min_gap = sorted_vals[i] - sorted_vals[i-1];
      last_idx = 1;
      for (int i = 1; i < n; i++)
        if (sorted_vals[i] - sorted_vals[i-1] == min_gap) last_idx = i;
      for (int i = 1; i < n; i++) begin
        if (sorted_vals[i] - sorted_vals[i-1] == min_gap) begin
          r = '{sorted_vals[i-1], sorted_vals[i], min_gap, 1'b1, set_overflow,
                i == last_idx};
          pending_pairs.push_back(r);
        end
      end
    end
    set_values.delete();
    set_overflow = 1'b0;
  endfunction

  always @(posedge clk) begin : result_check
    pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result: lower_value %0d, upper_value %0d",
               out_lower_value, out_upper_value);
        error_count = error_count + 1;
      end else begin
        want = pending_pairs.pop_front();
        if (out_lower_value !== $signed(want.lower)) begin
          $error("lower_value: expected %0d, got %0d", $signed(want.lower), out_lower_value);
          error_count = error_count + 1;
        end
        if (out_upper_value !== $signed(want.upper)) begin
          $error("upper_value: expected %0d, got %0d", $signed(want.upper), out_upper_value);
          error_count = error_count + 1;
        end
        if (out_pair_gap !== want.gap) begin
          $error("pair_gap: expected %h, got %h", want.gap, out_pair_gap);
          error_count = error_count + 1;
        end
        if (out_pair_present !== want.present) begin
          $error("pair_present: expected %b, got %b", want.present, out_pair_present);
          error_count = error_count + 1;
        end
        if (out_capacity_overflow !== want.overflow) begin
          $error("capacity_overflow: expected %b, got %b", want.overflow,
                 out_capacity_overflow);
          error_count = error_count + 1;
        end
        if (out_final_result !== want.final_flag) begin
          $error("final_result: expected %b, got %b", want.final_flag, out_final_result);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Receiver: long hold on request, otherwise always ready or a rotating random stall pattern.
  always @(posedge clk) begin
    pattern_age <= pattern_age + 1'b1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (!stall_en) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= stall_pattern[pattern_age[2:0]];
    end
    if (pattern_age == '0) stall_pattern <= 8'($urandom_range(1, 255));
  end

  task automatic send_sample(input logic [31:0] value, input logic last);
    if (idle_en && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_sample_value <= value;
    in_end_of_set <= last;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    predict_pairs(value, last);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pairs.size() != 0);
  endtask

  task automatic send_random_set(input int n, input spread_t spread);
    logic [31:0] base;
    logic [31:0] step;
    logic [31:0] value;
    int          offset;
    base = $urandom;
    step = 32'($urandom_range(1, 1000)) << $urandom_range(0, 16);
    offset = $urandom_range(0, 31);
    for (int i = 0; i < n; i++) begin
      case (spread)
        SPREAD_FULL:    value = $urandom;
        SPREAD_NARROW:  value = 32'($urandom_range(0, 40)) - 32'd20;
        SPREAD_LATTICE: value = base + step * 32'((i * 5 + offset) % n);
        SPREAD_CLUSTER: value = base + step * 32'($urandom_range(0, 7));
        default: begin
          case ($urandom_range(0, 4))
            0:       value = Q_MIN;
            1:       value = Q_MAX;
            2:       value = 32'd0;
            3:       value = 32'hffff_ffff;
            default: value = $urandom;
          endcase
        end
      endcase
      send_sample(value, i == n - 1);
    end
  endtask

  task automatic test_single_values();
    send_sample(Q_MIN, 1'b1);
    send_sample(Q_MAX, 1'b1);
    wait_for_results();
  endtask

  // widest possible gap
  task automatic test_extreme_pair();
    send_sample(Q_MAX, 1'b0);
    send_sample(Q_MIN, 1'b1);
    wait_for_results();
  endtask

  task automatic test_equal_gaps();
    send_sample(32'h0014_0000, 1'b0);
    send_sample(32'hfff6_0000, 1'b0);
    send_sample(32'h000a_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    wait_for_results();
  endtask

  // full store of duplicated values, closing value dropped
  task automatic test_full_store_overflow();
    for (int i = 0; i < CAPACITY; i++)
      send_sample((32'(i % 8) << 16) - 32'h0004_0000, 1'b0);
    send_sample(32'd12345, 1'b1);
    wait_for_results();
  endtask

  // output held off while sets keep coming back to back
  task automatic test_output_backpressure();
    idle_en = 1'b0;
    stall_en <= 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (3) send_random_set(10, SPREAD_CLUSTER);
    wait_for_results();
    idle_en = 1'b1;
  endtask

  task automatic test_random_sets();
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_en = sent >= QUIET_ITEMS;
      stall_en <= sent >= QUIET_ITEMS;
      pick = $urandom_range(0, 99);
      if (pick < 5) n = 1;
      else if (pick < 55) n = $urandom_range(2, 6);
      else if (pick < 80) n = $urandom_range(7, 12);
      else if (pick < 92) n = $urandom_range(13, CAPACITY);
      else n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      send_random_set(n, spread_t'($urandom_range(0, 4)));
      sent += n;
    end
    wait_for_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_single_values();
    test_extreme_pair();
    test_equal_gaps();
    test_full_store_overflow();
    test_output_backpressure();
    test_random_sets();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("closest_adjacent_pairs_finder_core test passed");
    end else begin
      $display("closest_adjacent_pairs_finder_core test failed");
    end
    $finish;
  end

endmodule
